// ===== hw/rtl/cidc_pkg.sv =====
// Shared widths, constants and the queue word type of the pairwise inverse
// distance block. Used by every module of the block; depends on nothing.
package cidc_pkg;

    localparam int COORD_W     = 25;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * COORD_W + 1;
    localparam int SUM_W       = PROD_W + 1;
    localparam int CUTOFF_W    = 20;
    localparam int CUT_SQ_W    = 2 * CUTOFF_W;
    localparam int OUT_W       = 26;
    localparam int QUO_W       = 2 * OUT_W;
    localparam int MILLI_SQ_W  = 20;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;
    localparam int QUEUE_DEPTH = 2;

    // Square of the milli-angstrom per angstrom scale.
    localparam logic [MILLI_SQ_W-1:0] MILLI_SQ     = MILLI_SQ_W'(1000000);
    localparam logic [CUTOFF_W-1:0]   CUTOFF_RESET = CUTOFF_W'(16000);
    localparam int                    INV_FRAC_BITS_DEF = 16;

    localparam logic [REG_IDX_W-1:0] REG_CUTOFF = REG_IDX_W'(0);

    // One classified pair handed from the front part to the back part.
    typedef struct packed {
        logic [CUT_SQ_W-1:0] dist_sq;
        logic                in_range;
        logic                no_contact;
        logic                last;
    } cidc_item_t;

endpackage

// ===== hw/rtl/cidc_front.sv =====
// Front part: coordinate differences, squares, squared distance, cutoff
// test and the sticky contact bit. Depends on cidc_pkg.
module cidc_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [cidc_pkg::COORD_W-1:0]    first_x,
    input  logic signed [cidc_pkg::COORD_W-1:0]    first_y,
    input  logic signed [cidc_pkg::COORD_W-1:0]    first_z,
    input  logic signed [cidc_pkg::COORD_W-1:0]    second_x,
    input  logic signed [cidc_pkg::COORD_W-1:0]    second_y,
    input  logic signed [cidc_pkg::COORD_W-1:0]    second_z,
    input  logic                                   last_pair,
    input  logic                                   push,
    output logic                                   full,
    input  logic [cidc_pkg::CUTOFF_W-1:0]          cutoff,
    output cidc_pkg::cidc_item_t                   item,
    output logic                                   item_valid,
    input  logic                                   item_ready
);
    import cidc_pkg::*;

    logic                     advance;
    logic                     v1_reg, v2_reg, v3_reg;
    logic                     seen_reg, seen_next;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic                     last1_reg, last2_reg;
    logic [PROD_W-1:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [CUT_SQ_W-1:0]      cut_sq_reg;
    cidc_item_t               item_reg, item_next;
    logic [DIFF_W-1:0]        ax, ay, az;
    logic [2*DIFF_W-1:0]      px, py, pz;
    logic [SUM_W-1:0]         sum;

    // The whole pipeline holds while its last stage waits on the queue.
    assign advance    = !(v3_reg && !item_ready);
    assign full       = !advance;
    assign item_valid = v3_reg;
    assign item       = item_reg;

    assign ax = dx_reg[DIFF_W-1] ? $unsigned(-dx_reg) : $unsigned(dx_reg);
    assign ay = dy_reg[DIFF_W-1] ? $unsigned(-dy_reg) : $unsigned(dy_reg);
    assign az = dz_reg[DIFF_W-1] ? $unsigned(-dz_reg) : $unsigned(dz_reg);
    assign px = ax * ax;
    assign py = ay * ay;
    assign pz = az * az;

    assign sum = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);

    always_comb
    begin
        item_next.in_range = (sum <= SUM_W'(cut_sq_reg));
        item_next.dist_sq  = sum[CUT_SQ_W-1:0];
        item_next.last     = last2_reg;
        seen_next          = seen_reg | item_next.in_range;
        item_next.no_contact = 1'b0;
        if (last2_reg)
        begin
            item_next.no_contact = !seen_next;
            seen_next            = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            seen_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (v2_reg)
            begin
                seen_reg <= seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cut_sq_reg <= CUT_SQ_W'(cutoff) * CUT_SQ_W'(cutoff);
        if (advance)
        begin
            dx_reg    <= DIFF_W'(first_x) - DIFF_W'(second_x);
            dy_reg    <= DIFF_W'(first_y) - DIFF_W'(second_y);
            dz_reg    <= DIFF_W'(first_z) - DIFF_W'(second_z);
            last1_reg <= last_pair;
            sqx_reg   <= px[PROD_W-1:0];
            sqy_reg   <= py[PROD_W-1:0];
            sqz_reg   <= pz[PROD_W-1:0];
            last2_reg <= last1_reg;
            item_reg  <= item_next;
        end
    end

endmodule

// ===== hw/rtl/cidc_queue.sv =====
// Short queue of classified words between the front and back parts.
// Depends on cidc_pkg for the word type.
module cidc_queue #(
    parameter int DEPTH = cidc_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cidc_pkg::cidc_item_t in_item,
    input  logic                 in_valid,
    output logic                 in_ready,
    output cidc_pkg::cidc_item_t out_item,
    output logic                 out_valid,
    input  logic                 out_ready
);
    import cidc_pkg::*;

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cidc_item_t         slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_wr, do_rd;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== hw/rtl/cidc_back.sv =====
// Back part: the shared iterative unit that divides the squared scale by the
// squared distance, then takes the integer square root, plus the output
// register. Depends on cidc_pkg.
module cidc_back #(
    parameter int INV_FRAC_BITS = cidc_pkg::INV_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cidc_pkg::cidc_item_t          item,
    input  logic                          item_valid,
    output logic                          item_ready,
    output logic [cidc_pkg::OUT_W-1:0]    inv_distance,
    output logic                          within_cutoff,
    output logic                          no_contact,
    output logic                          end_of_matrix,
    output logic                          empty,
    input  logic                          pop
);
    import cidc_pkg::*;

    // floor(K / s) is found with QUO_W quotient bits; its integer square root
    // is the result, since r*r*s <= K holds exactly when r*r <= floor(K / s).
    localparam int KW     = MILLI_SQ_W + 2 * INV_FRAC_BITS;
    localparam int KEW    = (KW > QUO_W) ? KW : QUO_W + 1;
    localparam int REM_W  = CUT_SQ_W + 1;
    localparam int STEP_W = $clog2(QUO_W);
    localparam logic [KEW-1:0]   K_EXT   = KEW'(MILLI_SQ) << (2 * INV_FRAC_BITS);
    localparam logic [REM_W-1:0] K_TOP   = REM_W'(K_EXT[KEW-1:QUO_W]);
    localparam logic [QUO_W-1:0] K_LOW   = K_EXT[QUO_W-1:0];
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [CUT_SQ_W-1:0]  divisor_reg, divisor_next;
    logic [QUO_W-1:0]     kbits_reg, kbits_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [OUT_W-1:0]     root_reg, root_next;
    logic [OUT_W-1:0]     res_reg, res_next;
    logic                 within_reg, within_next;
    logic                 none_reg, none_next;
    logic                 last_reg, last_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_inv_reg, out_inv_next;
    logic                 out_within_reg, out_within_next;
    logic                 out_none_reg, out_none_next;
    logic                 out_last_reg, out_last_next;
    logic [REM_W-1:0]     div_trial;
    logic                 div_ge;
    logic [OUT_W+1:0]     sq_trial, sq_sub;
    logic                 sq_ge;
    logic                 pop_ok, out_load;

    assign item_ready    = (state_reg == ST_IDLE);
    assign empty         = !out_valid_reg;
    assign inv_distance  = out_inv_reg;
    assign within_cutoff = out_within_reg;
    assign no_contact    = out_none_reg;
    assign end_of_matrix = out_last_reg;

    assign pop_ok   = pop && out_valid_reg;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || pop);

    // One restoring division step and one square root digit step.
    assign div_trial = {rem_reg[REM_W-2:0], kbits_reg[QUO_W-1]};
    assign div_ge    = (div_trial >= REM_W'(divisor_reg));
    assign sq_trial  = {rem_reg[OUT_W-1:0], quo_reg[QUO_W-1:QUO_W-2]};
    assign sq_sub    = {root_reg, 2'b01};
    assign sq_ge     = (sq_trial >= sq_sub);

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        kbits_next      = kbits_reg;
        quo_next        = quo_reg;
        root_next       = root_reg;
        res_next        = res_reg;
        within_next     = within_reg;
        none_next       = none_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        out_inv_next    = out_inv_reg;
        out_within_next = out_within_reg;
        out_none_next   = out_none_reg;
        out_last_next   = out_last_reg;

        if (pop_ok)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    divisor_next = item.dist_sq;
                    within_next  = item.in_range;
                    none_next    = item.no_contact;
                    last_next    = item.last;
                    if (!item.in_range)
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else if (K_TOP >= REM_W'(item.dist_sq))
                    begin
                        // Quotient too wide for the output, zero distance included.
                        res_next   = OUT_MAX;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rem_next   = K_TOP;
                        kbits_next = K_LOW;
                        quo_next   = '0;
                        step_next  = STEP_W'(QUO_W - 1);
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next   = div_ge ? div_trial - REM_W'(divisor_reg) : div_trial;
                quo_next   = {quo_reg[QUO_W-2:0], div_ge};
                kbits_next = {kbits_reg[QUO_W-2:0], 1'b0};
                if (step_reg == '0)
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = STEP_W'(OUT_W - 1);
                    state_next = ST_SQRT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_SQRT:
            begin
                rem_next  = REM_W'(sq_ge ? sq_trial - sq_sub : sq_trial);
                root_next = {root_reg[OUT_W-2:0], sq_ge};
                quo_next  = {quo_reg[QUO_W-3:0], 2'b00};
                if (step_reg == '0)
                begin
                    res_next   = root_next;
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_inv_next    = res_reg;
                    out_within_next = within_reg;
                    out_none_next   = none_reg;
                    out_last_next   = last_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            rem_reg        <= '0;
            divisor_reg    <= '0;
            kbits_reg      <= '0;
            quo_reg        <= '0;
            root_reg       <= '0;
            res_reg        <= '0;
            within_reg     <= 1'b0;
            none_reg       <= 1'b0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_inv_reg    <= '0;
            out_within_reg <= 1'b0;
            out_none_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            rem_reg        <= rem_next;
            divisor_reg    <= divisor_next;
            kbits_reg      <= kbits_next;
            quo_reg        <= quo_next;
            root_reg       <= root_next;
            res_reg        <= res_next;
            within_reg     <= within_next;
            none_reg       <= none_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
            out_inv_reg    <= out_inv_next;
            out_within_reg <= out_within_next;
            out_none_reg   <= out_none_next;
            out_last_reg   <= out_last_next;
        end
    end

endmodule

// ===== hw/rtl/cross_inverse_distogram_contact.sv =====
// Top level of the pairwise inverse distance block: configuration port and
// the front part, queue and back part. Depends on cidc_pkg and its modules.
//
// Each pushed word holds two atoms; each popped word is one matrix cell with
// the reciprocal distance in unsigned fixed point with INV_FRAC_BITS fraction
// bits, zero beyond the cutoff and saturated at the top of its range. The
// front part is a three-stage pipeline (differences, squares, sum and cutoff
// test) and feeds a two-word queue. The back part works on one word at a time
// in a shared bit-serial unit, taking none until the last is handed on: a
// pair within the cutoff that does not saturate passes setup, 52 restoring
// division steps, 26 square root steps and the hand-off to the output
// register; other pairs skip the division and square root. The cutoff
// register sits at byte address 0; the user must write it only while the
// block holds no pending word, as the block itself does not enforce this.
module cross_inverse_distogram_contact #(
    parameter int INV_FRAC_BITS = cidc_pkg::INV_FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [cidc_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [cidc_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [cidc_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    input  logic signed [cidc_pkg::COORD_W-1:0]    first_x,
    input  logic signed [cidc_pkg::COORD_W-1:0]    first_y,
    input  logic signed [cidc_pkg::COORD_W-1:0]    first_z,
    input  logic signed [cidc_pkg::COORD_W-1:0]    second_x,
    input  logic signed [cidc_pkg::COORD_W-1:0]    second_y,
    input  logic signed [cidc_pkg::COORD_W-1:0]    second_z,
    input  logic                                   last_pair,
    input  logic                                   push,
    output logic                                   full,
    output logic [cidc_pkg::OUT_W-1:0]             inv_distance,
    output logic                                   within_cutoff,
    output logic                                   no_contact,
    output logic                                   end_of_matrix,
    output logic                                   empty,
    input  logic                                   pop
);
    import cidc_pkg::*;

    logic [CUTOFF_W-1:0] cutoff_reg;
    logic                cfg_hit;
    cidc_item_t          front_item, back_item;
    logic                front_valid, front_ready;
    logic                back_valid, back_ready;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[APB_ADDR_W-1:2] == REG_CUTOFF);
    assign prdata  = cfg_hit ? APB_DATA_W'(cutoff_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= CUTOFF_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            cutoff_reg <= pwdata[CUTOFF_W-1:0];
        end
    end

    cidc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .first_x    (first_x),
        .first_y    (first_y),
        .first_z    (first_z),
        .second_x   (second_x),
        .second_y   (second_y),
        .second_z   (second_z),
        .last_pair  (last_pair),
        .push       (push),
        .full       (full),
        .cutoff     (cutoff_reg),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    cidc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (front_item),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_item  (back_item),
        .out_valid (back_valid),
        .out_ready (back_ready)
    );

    cidc_back #(
        .INV_FRAC_BITS (INV_FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (back_item),
        .item_valid    (back_valid),
        .item_ready    (back_ready),
        .inv_distance  (inv_distance),
        .within_cutoff (within_cutoff),
        .no_contact    (no_contact),
        .end_of_matrix (end_of_matrix),
        .empty         (empty),
        .pop           (pop)
    );

endmodule
